// ===== design/pms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    // Field and configuration widths
    localparam int PIXEL_W   = 8;
    localparam int DIM_W     = 15;
    localparam int DIM_MAX   = 16384;
    localparam int FRAC_BITS = 8;
    localparam int MEAN_W    = 16;
    localparam int SDEV_W    = 15;

    // Accumulator widths; the count must hold DIM_MAX squared itself
    localparam int SIZE_W = 29;
    localparam int SUM_W  = 36;
    localparam int SQ_W   = 44;

    // Shift-add multiplier: product of count and square sum, plus a sign bit
    localparam int PROD_W   = SQ_W + SIZE_W + 1;
    localparam int ACC_W    = PROD_W + 1;
    localparam int MPLIER_W = SUM_W;

    // Integer square root of the scaled numerator, two radicand bits a step
    localparam int RAD_W  = PROD_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 2;

    // Restoring divider, one quotient bit a step
    localparam int DVD_W  = ROOT_W;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] DIV_STEPS   = STEP_W'(DVD_W);
    localparam logic [STEP_W-1:0] MUL_Q_STEPS = STEP_W'(SIZE_W);
    localparam logic [STEP_W-1:0] MUL_S_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] ROOT_STEPS  = STEP_W'(ROOT_W);

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES_PER_LINE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_COUNT       = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MEAN_DIV,
        ST_MUL_Q,
        ST_MUL_S,
        ST_ROOT,
        ST_SD_DIV,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DIV_MEAN,
        OP_MUL_Q,
        OP_MUL_S,
        OP_ROOT,
        OP_DIV_SD
    } op_t;

    typedef struct packed {
        logic take;
        op_t  op;
        logic init;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic frame_last;
        logic out_free;
    } status_t;

    // A zero dimension counts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_MAX)) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/pms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire pms_pkg::status_t status,
    output pms_pkg::cmd_t         cmd
);

    pms_pkg::state_t              state_reg, state_next;
    logic [pms_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         phase_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pms_pkg::ST_ACCUM;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Each arithmetic phase first loads its unit, then runs its steps.
    always_comb begin
        case (state_reg)
            pms_pkg::ST_MEAN_DIV: phase_done = (step_reg == pms_pkg::DIV_STEPS);
            pms_pkg::ST_MUL_Q:    phase_done = (step_reg == pms_pkg::MUL_Q_STEPS);
            pms_pkg::ST_MUL_S:    phase_done = (step_reg == pms_pkg::MUL_S_STEPS);
            pms_pkg::ST_ROOT:     phase_done = (step_reg == pms_pkg::ROOT_STEPS);
            pms_pkg::ST_SD_DIV:   phase_done = (step_reg == pms_pkg::DIV_STEPS);
            default:              phase_done = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            pms_pkg::ST_ACCUM: begin
                step_next = '0;
                if (s_tvalid && status.frame_last) begin
                    state_next = pms_pkg::ST_MEAN_DIV;
                end
            end
            pms_pkg::ST_MEAN_DIV, pms_pkg::ST_MUL_Q, pms_pkg::ST_MUL_S,
            pms_pkg::ST_ROOT, pms_pkg::ST_SD_DIV: begin
                if (phase_done) begin
                    step_next = '0;
                    case (state_reg)
                        pms_pkg::ST_MEAN_DIV: state_next = pms_pkg::ST_MUL_Q;
                        pms_pkg::ST_MUL_Q:    state_next = pms_pkg::ST_MUL_S;
                        pms_pkg::ST_MUL_S:    state_next = pms_pkg::ST_ROOT;
                        pms_pkg::ST_ROOT:     state_next = pms_pkg::ST_SD_DIV;
                        default:              state_next = pms_pkg::ST_OUTPUT;
                    endcase
                end else begin
                    step_next = step_reg + pms_pkg::STEP_W'(1);
                end
            end
            pms_pkg::ST_OUTPUT: begin
                step_next = '0;
                if (status.out_free) begin
                    state_next = pms_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = pms_pkg::ST_ACCUM;
                step_next  = '0;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = pms_pkg::OP_IDLE;
        cmd.init     = (step_reg == '0);
        case (state_reg)
            pms_pkg::ST_ACCUM:    cmd.take     = 1'b1;
            pms_pkg::ST_MEAN_DIV: cmd.op       = pms_pkg::OP_DIV_MEAN;
            pms_pkg::ST_MUL_Q:    cmd.op       = pms_pkg::OP_MUL_Q;
            pms_pkg::ST_MUL_S:    cmd.op       = pms_pkg::OP_MUL_S;
            pms_pkg::ST_ROOT:     cmd.op       = pms_pkg::OP_ROOT;
            pms_pkg::ST_SD_DIV:   cmd.op       = pms_pkg::OP_DIV_SD;
            pms_pkg::ST_OUTPUT:   cmd.out_load = status.out_free;
            default:              cmd.op       = pms_pkg::OP_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/pms_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pms_pkg::cmd_t               cmd,
    output pms_pkg::status_t                 status,
    input  wire logic [pms_pkg::SIZE_W-1:0]  frame_size,
    input  wire logic                        s_tvalid,
    input  wire logic [pms_pkg::PIXEL_W-1:0] pixel,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [pms_pkg::MEAN_W-1:0]       mean_q8,
    output logic [pms_pkg::SDEV_W-1:0]       stddev_q8
);

    // Accumulators
    logic [pms_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [pms_pkg::SQ_W-1:0]     sq_reg, sq_next;
    logic [pms_pkg::SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [pms_pkg::SIZE_W-1:0]   cnt_inc;
    logic [2*pms_pkg::PIXEL_W-1:0] pix_sq;
    logic                         accept;

    // Divider
    logic [pms_pkg::DVD_W-1:0]    dvd_reg, dvd_next;
    logic [pms_pkg::DVD_W-1:0]    quo_reg, quo_next;
    logic [pms_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic [pms_pkg::SIZE_W:0]     div_trial;
    logic                         div_fits;

    // Multiplier
    logic [pms_pkg::PROD_W-1:0]   mcand_reg, mcand_next;
    logic [pms_pkg::MPLIER_W-1:0] mplier_reg, mplier_next;
    logic [pms_pkg::ACC_W-1:0]    acc_reg, acc_next;

    // Square root
    logic [pms_pkg::RAD_W-1:0]    rad_reg, rad_next;
    logic [pms_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [pms_pkg::SREM_W-1:0]   srem_reg, srem_next;
    logic [pms_pkg::SREM_W+1:0]   sq_trial, sq_sub;

    // Results
    logic [pms_pkg::MEAN_W-1:0]   mean_reg, mean_next;
    logic [pms_pkg::MEAN_W-1:0]   mean_sat;
    logic [pms_pkg::SDEV_W-1:0]   sdev_sat;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pms_pkg::MEAN_W-1:0]   m_mean_reg, m_mean_next;
    logic [pms_pkg::SDEV_W-1:0]   m_sdev_reg, m_sdev_next;

    assign accept  = s_tvalid && cmd.take;
    assign cnt_inc = cnt_reg + pms_pkg::SIZE_W'(1);
    assign pix_sq  = {{pms_pkg::PIXEL_W{1'b0}}, pixel} * {{pms_pkg::PIXEL_W{1'b0}}, pixel};

    // The frame ends on the first pixel at which the count reaches or passes the size.
    assign status.frame_last = (cnt_inc >= frame_size);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            sum_next = sum_reg + pms_pkg::SUM_W'(pixel);
            sq_next  = sq_reg + pms_pkg::SQ_W'(pix_sq);
            cnt_next = cnt_inc;
        end else if (cmd.out_load) begin
            sum_next = '0;
            sq_next  = '0;
            cnt_next = '0;
        end
    end

    // Restoring division by the pixel count, shared by the mean and the deviation.
    assign div_trial = {rem_reg, dvd_reg[pms_pkg::DVD_W-1]};
    assign div_fits  = (div_trial >= {1'b0, cnt_reg});

    always_comb begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.op inside {pms_pkg::OP_DIV_MEAN, pms_pkg::OP_DIV_SD}) begin
            if (cmd.init) begin
                quo_next = '0;
                rem_next = '0;
                if (cmd.op == pms_pkg::OP_DIV_MEAN) begin
                    dvd_next = pms_pkg::DVD_W'(sum_reg) << pms_pkg::FRAC_BITS;
                end else begin
                    dvd_next = pms_pkg::DVD_W'(root_reg);
                end
            end else begin
                dvd_next = dvd_reg << 1;
                quo_next = {quo_reg[pms_pkg::DVD_W-2:0], div_fits};
                if (div_fits) begin
                    rem_next = pms_pkg::SIZE_W'(div_trial - {1'b0, cnt_reg});
                end else begin
                    rem_next = div_trial[pms_pkg::SIZE_W-1:0];
                end
            end
        end
    end

    // Shift-add multiplier: accumulates count times square sum, then takes off sum squared.
    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (cmd.op == pms_pkg::OP_MUL_Q || cmd.op == pms_pkg::OP_MUL_S) begin
            if (cmd.init) begin
                if (cmd.op == pms_pkg::OP_MUL_Q) begin
                    acc_next    = '0;
                    mcand_next  = pms_pkg::PROD_W'(sq_reg);
                    mplier_next = pms_pkg::MPLIER_W'(cnt_reg);
                end else begin
                    mcand_next  = pms_pkg::PROD_W'(sum_reg);
                    mplier_next = pms_pkg::MPLIER_W'(sum_reg);
                end
            end else begin
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (mplier_reg[0]) begin
                    if (cmd.op == pms_pkg::OP_MUL_Q) begin
                        acc_next = acc_reg + pms_pkg::ACC_W'(mcand_reg);
                    end else begin
                        acc_next = acc_reg - pms_pkg::ACC_W'(mcand_reg);
                    end
                end
            end
        end
    end

    // Digit-by-digit square root, two radicand bits per step.
    assign sq_trial = {srem_reg, rad_reg[pms_pkg::RAD_W-1 -: 2]};
    assign sq_sub   = sq_trial - {1'b0, root_reg, 2'b01};

    always_comb begin
        rad_next  = rad_reg;
        root_next = root_reg;
        srem_next = srem_reg;
        if (cmd.op == pms_pkg::OP_ROOT) begin
            if (cmd.init) begin
                root_next = '0;
                srem_next = '0;
                if (acc_reg[pms_pkg::ACC_W-1]) begin
                    rad_next = '0;
                end else begin
                    rad_next = pms_pkg::RAD_W'(acc_reg[pms_pkg::PROD_W-1:0])
                               << (2 * pms_pkg::FRAC_BITS);
                end
            end else begin
                rad_next = rad_reg << 2;
                if (!sq_sub[pms_pkg::SREM_W+1]) begin
                    srem_next = sq_sub[pms_pkg::SREM_W-1:0];
                    root_next = {root_reg[pms_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = sq_trial[pms_pkg::SREM_W-1:0];
                    root_next = {root_reg[pms_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate quotients that would overflow their fields.
    assign mean_sat = (|quo_reg[pms_pkg::DVD_W-1:pms_pkg::MEAN_W]) ?
                      '1 : quo_reg[pms_pkg::MEAN_W-1:0];
    assign sdev_sat = (|quo_reg[pms_pkg::DVD_W-1:pms_pkg::SDEV_W]) ?
                      '1 : quo_reg[pms_pkg::SDEV_W-1:0];

    always_comb begin
        mean_next     = mean_reg;
        m_tvalid_next = m_tvalid_reg;
        m_mean_next   = m_mean_reg;
        m_sdev_next   = m_sdev_reg;
        // The mean quotient is still in the divider when the multiplier loads.
        if (cmd.op == pms_pkg::OP_MUL_Q && cmd.init) begin
            mean_next = mean_sat;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_mean_next   = mean_reg;
            m_sdev_next   = sdev_sat;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            sq_reg       <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        mean_reg   <= mean_next;
        m_mean_reg <= m_mean_next;
        m_sdev_reg <= m_sdev_next;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign mean_q8   = m_mean_reg;
    assign stddev_q8 = m_sdev_reg;

    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.take |-> cnt_reg != '0)
        else $error("pixel count is zero while a frame is being finished");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.op == pms_pkg::OP_DIV_MEAN || cmd.op == pms_pkg::OP_DIV_SD) && !cmd.init)
        |-> rem_reg < cnt_reg)
        else $error("divider remainder is not below the pixel count");

    a_numerator_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == pms_pkg::OP_ROOT && cmd.init) |-> !acc_reg[pms_pkg::ACC_W-1])
        else $error("variance numerator came out negative");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid_reg && sum_reg == '0 && cnt_reg == '0)
        else $error("result load did not present a result and clear the sums");

endmodule

`default_nettype wire

// ===== design/pixel_mean_and_stddev_top.sv =====
// Image mean and population standard deviation, unsigned Q8.8 and Q7.8.
// Pixels arrive on the s_ stream, one 8-bit pixel per request in s_tdata.
// The frame size is samples_per_line times line_count. The user must write
// them through the cfg_we / cfg_addr / cfg_wdata port while the block is
// idle; the block does not enforce this. A zero value counts as one and a
// value above 16384 counts as 16384. Within a frame a pixel is taken every
// cycle. On the last pixel s_tready drops and the frame-end arithmetic runs:
// a 45-step restoring divider for the mean, a shift-add multiplier of 29
// plus 36 steps for the variance numerator, a 45-step square root and the
// same divider again for the deviation, each loading its unit first. The
// result then moves into the output register, which raises m_tvalid, and
// s_tready rises with it; the next frame streams in while the result waits.
// If the receiver still holds an earlier result, the new one waits, with
// s_tready low, until that is taken.
// Reset clears the sums, the count and the output valid, and sets both
// dimensions to one.
`timescale 1ns / 1ps
`default_nettype none

module pixel_mean_and_stddev_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pms_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] pixel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [pms_pkg::TDATA_OUT_W-1:0]         m_tdata,   // [15:0] mean_q8, [30:16] stddev_q8
    input  wire logic                               cfg_we,
    input  wire logic [pms_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [pms_pkg::DIM_W-1:0]          cfg_wdata
);

    logic [pms_pkg::DIM_W-1:0]  spl_reg, spl_next;
    logic [pms_pkg::DIM_W-1:0]  lines_reg, lines_next;
    logic [pms_pkg::SIZE_W-1:0] frame_size;
    logic [pms_pkg::DIM_W-1:0]  spl_eff, lines_eff;
    logic [pms_pkg::MEAN_W-1:0] mean_q8;
    logic [pms_pkg::SDEV_W-1:0] stddev_q8;
    pms_pkg::cmd_t              cmd;
    pms_pkg::status_t           status;

    always_comb begin
        spl_next   = spl_reg;
        lines_next = lines_reg;
        if (cfg_we) begin
            case (cfg_addr)
                pms_pkg::REG_SAMPLES_PER_LINE: spl_next   = cfg_wdata;
                pms_pkg::REG_LINE_COUNT:       lines_next = cfg_wdata;
                default:                       spl_next   = spl_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spl_reg   <= pms_pkg::DIM_W'(1);
            lines_reg <= pms_pkg::DIM_W'(1);
        end else begin
            spl_reg   <= spl_next;
            lines_reg <= lines_next;
        end
    end

    assign spl_eff    = pms_pkg::eff_dim(spl_reg);
    assign lines_eff  = pms_pkg::eff_dim(lines_reg);
    assign frame_size = pms_pkg::SIZE_W'(spl_eff) * pms_pkg::SIZE_W'(lines_eff);

    pms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    pms_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .frame_size (frame_size),
        .s_tvalid   (s_tvalid),
        .pixel      (s_tdata[pms_pkg::PIXEL_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mean_q8    (mean_q8),
        .stddev_q8  (stddev_q8)
    );

    assign s_tready = cmd.take;
    assign m_tdata  = pms_pkg::TDATA_OUT_W'({stddev_q8, mean_q8});

endmodule

`default_nettype wire
